// ----- hw/rtl/msp_pkg.sv -----
// Shared types, constants and command/status structs of the mark-and-sweep slot pool.
package msp_pkg;

    // Field widths of the stream payloads and the configuration register.
    localparam int SLOT_W = 6;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;
    localparam int ECNT_W = 7;

    // Default pool size and the cap on reported frees per sweep.
    localparam int POOL_SLOTS_DEF = 64;
    localparam int MAX_RESULTS    = 64;

    // Reset value of the expansion count register.
    localparam logic [ECNT_W-1:0] EXPAND_RESET = 7'd8;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MARK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SWEEP = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL        = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_MARK    = 2'd2;
    localparam logic [STAT_W-1:0] ST_SWEEP_EMPTY = 2'd3;

    // Per-slot flag bits.
    localparam logic [1:0] FLAG_MARKED = 2'b01;
    localparam logic [1:0] FLAG_FREE   = 2'b10;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // latch the request slot
        logic exp_start;  // set up an expansion group
        logic exp_step;   // open one slot of the group
        logic link_rd;    // read the link of the free-list head
        logic pop;        // pop the head and report it
        logic full_err;   // report out of space
        logic mark_rd;    // read the flags of the slot to mark
        logic mark_fin;   // set the mark bit or report a bad mark
        logic sw_start;   // begin a sweep at the newest group
        logic grp_rd;     // read the start of the group below the end
        logic grp_load;   // load the group start as the sweep cursor
        logic sw_rd;      // read the flags at the sweep cursor
        logic sw_eval;    // free or unmark the slot at the cursor
        logic sw_fin;     // deliver the final sweep result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic list_empty; // free list holds no slot
        logic exp_fits;   // next group fits into the pool
        logic exp_last;   // expansion cursor is on the last slot of its group
        logic end_zero;   // sweep has passed the oldest group
        logic cur_last;   // sweep cursor is on the last slot of its group
        logic sw_stall;   // sweep must wait for the output register
    } t_sts;

endpackage

// ----- hw/rtl/msp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module msp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/msp_ctrl.sv -----
// Controller state machine of the slot pool: sequences allocate, mark and sweep.
module msp_ctrl
    import msp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic [KIND_W-1:0] i_req_kind,
    output logic              o_req_ready,
    input  t_sts              i_sts,
    output t_cmd              o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_AL_CHK,
        S_AL_EXP,
        S_AL_RD,
        S_AL_POP,
        S_AL_ERR,
        S_MK_RD,
        S_MK_EV,
        S_SW_GRP,
        S_SW_GS,
        S_SW_RD,
        S_SW_EV,
        S_SW_END
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   w_cmd;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    w_cmd.load = 1'b1;
                    unique case (i_req_kind)
                        KIND_ALLOC: n_state = S_AL_CHK;
                        KIND_MARK:  n_state = S_MK_RD;
                        KIND_SWEEP: begin
                            w_cmd.sw_start = 1'b1;
                            n_state        = S_SW_GRP;
                        end
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_AL_CHK: begin
                if (!i_sts.list_empty) begin
                    w_cmd.link_rd = 1'b1;
                    n_state       = S_AL_POP;
                end else if (i_sts.exp_fits) begin
                    w_cmd.exp_start = 1'b1;
                    n_state         = S_AL_EXP;
                end else begin
                    n_state = S_AL_ERR;
                end
            end
            S_AL_EXP: begin
                w_cmd.exp_step = 1'b1;
                if (i_sts.exp_last) begin
                    n_state = S_AL_RD;
                end
            end
            S_AL_RD: begin
                w_cmd.link_rd = 1'b1;
                n_state       = S_AL_POP;
            end
            S_AL_POP: begin
                if (i_sts.out_free) begin
                    w_cmd.pop = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_AL_ERR: begin
                if (i_sts.out_free) begin
                    w_cmd.full_err = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_MK_RD: begin
                w_cmd.mark_rd = 1'b1;
                n_state       = S_MK_EV;
            end
            S_MK_EV: begin
                if (i_sts.out_free) begin
                    w_cmd.mark_fin = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SW_GRP: begin
                if (i_sts.end_zero) begin
                    n_state = S_SW_END;
                end else begin
                    w_cmd.grp_rd = 1'b1;
                    n_state      = S_SW_GS;
                end
            end
            S_SW_GS: begin
                w_cmd.grp_load = 1'b1;
                n_state        = S_SW_RD;
            end
            S_SW_RD: begin
                w_cmd.sw_rd = 1'b1;
                n_state     = S_SW_EV;
            end
            S_SW_EV: begin
                if (!i_sts.sw_stall) begin
                    w_cmd.sw_eval = 1'b1;
                    n_state       = i_sts.cur_last ? S_SW_GRP : S_SW_RD;
                end
            end
            S_SW_END: begin
                if (i_sts.out_free) begin
                    w_cmd.sw_fin = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_req_ready = (r_state == S_IDLE);

endmodule

// ----- hw/rtl/msp_dp.sv -----
// Datapath of the slot pool: flag, link and group memories, list head and result register.
module msp_dp
    import msp_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [ECNT_W-1:0] i_expand_count,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output logic [SLOT_W-1:0] o_m_slot,
    output logic [STAT_W-1:0] o_m_status,
    output logic              o_m_last
);

    // Address width, count width (holds POOL_SLOTS itself) and compare widths.
    localparam int SW = $clog2(POOL_SLOTS);
    localparam int CW = $clog2(POOL_SLOTS + 1);
    localparam int XW = (CW > SLOT_W) ? CW : SLOT_W;
    localparam int MW = ((CW > ECNT_W) ? CW : ECNT_W) + 1;
    localparam int KW = $clog2(MAX_RESULTS + 1);

    // List and pool state.
    logic [CW-1:0]     r_top;
    logic [CW-1:0]     r_opened;
    logic [CW-1:0]     r_cursor;
    logic [CW-1:0]     r_exp_end;
    logic [SLOT_W-1:0] r_slot;

    // Sweep state.
    logic [CW-1:0]     r_end;
    logic [SW-1:0]     r_start;
    logic [SW-1:0]     r_cur;
    logic [SW-1:0]     r_pend;
    logic              r_pend_v;
    logic [KW-1:0]     r_k;

    // Result register.
    logic              r_out_valid;
    logic [SLOT_W-1:0] r_out_slot;
    logic [STAT_W-1:0] r_out_status;
    logic              r_out_last;

    // Memory ports.
    logic          w_mk_we;
    logic [SW-1:0] w_mk_waddr;
    logic [1:0]    w_mk_wdata;
    logic          w_mk_re;
    logic [SW-1:0] w_mk_raddr;
    logic [1:0]    w_mk_rdata;
    logic          w_lk_we;
    logic [SW-1:0] w_lk_waddr;
    logic          w_lk_re;
    logic [CW-1:0] w_lk_rdata;
    logic [SW-1:0] w_gr_raddr;
    logic [SW-1:0] w_gr_rdata;

    // Derived values.
    logic [ECNT_W-1:0] w_n;
    logic [MW-1:0]     w_exp_sum;
    logic              w_in_range;
    logic              w_bad_mark;
    logic              w_do_free;
    logic              w_report;
    logic              w_out_free;
    logic              w_emit;
    logic [SLOT_W-1:0] w_emit_slot;
    logic [STAT_W-1:0] w_emit_status;
    logic              w_emit_last;

    // An expansion count of zero opens one slot.
    assign w_n       = (i_expand_count == '0) ? ECNT_W'(1) : i_expand_count;
    assign w_exp_sum = MW'(r_opened) + MW'(w_n);

    assign w_in_range = XW'(r_slot) < XW'(r_opened);
    assign w_bad_mark = !w_in_range || ((w_mk_rdata & FLAG_FREE) != '0);
    assign w_do_free  = (w_mk_rdata == 2'b00);
    assign w_report   = r_k < KW'(MAX_RESULTS);
    assign w_out_free = !r_out_valid || i_m_tready;

    // Status to the controller.
    always_comb begin
        o_sts.out_free   = w_out_free;
        o_sts.list_empty = (r_top == CW'(POOL_SLOTS));
        o_sts.exp_fits   = (w_exp_sum <= MW'(POOL_SLOTS));
        o_sts.exp_last   = ((r_cursor + CW'(1)) == r_exp_end);
        o_sts.end_zero   = (r_end == '0);
        o_sts.cur_last   = ((CW'(r_cur) + CW'(1)) == r_end);
        o_sts.sw_stall   = w_do_free && w_report && r_pend_v && !w_out_free;
    end

    // Flag memory port selection.
    always_comb begin
        w_mk_re    = i_cmd.mark_rd || i_cmd.sw_rd;
        w_mk_raddr = i_cmd.mark_rd ? SW'(r_slot) : r_cur;
        w_mk_we    = 1'b0;
        w_mk_waddr = r_cur;
        w_mk_wdata = FLAG_FREE;
        if (i_cmd.exp_step) begin
            w_mk_we    = 1'b1;
            w_mk_waddr = SW'(r_cursor);
            w_mk_wdata = FLAG_FREE;
        end else if (i_cmd.pop) begin
            w_mk_we    = 1'b1;
            w_mk_waddr = SW'(r_top);
            w_mk_wdata = 2'b00;
        end else if (i_cmd.mark_fin) begin
            w_mk_we    = !w_bad_mark;
            w_mk_waddr = SW'(r_slot);
            w_mk_wdata = w_mk_rdata | FLAG_MARKED;
        end else if (i_cmd.sw_eval) begin
            w_mk_we    = 1'b1;
            w_mk_waddr = r_cur;
            w_mk_wdata = w_do_free ? FLAG_FREE : (w_mk_rdata & ~FLAG_MARKED);
        end
    end

    // Link memory: pushes during expansion and sweep, reads of the list head.
    assign w_lk_we    = i_cmd.exp_step || (i_cmd.sw_eval && w_do_free);
    assign w_lk_waddr = i_cmd.exp_step ? SW'(r_cursor) : r_cur;
    assign w_lk_re    = i_cmd.link_rd;
    assign w_gr_raddr = SW'(r_end - CW'(1));

    msp_ram #(
        .WIDTH (2),
        .DEPTH (POOL_SLOTS)
    ) u_marks (
        .i_clk   (i_clk),
        .i_we    (w_mk_we),
        .i_waddr (w_mk_waddr),
        .i_wdata (w_mk_wdata),
        .i_re    (w_mk_re),
        .i_raddr (w_mk_raddr),
        .o_rdata (w_mk_rdata)
    );

    msp_ram #(
        .WIDTH (CW),
        .DEPTH (POOL_SLOTS)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (w_lk_we),
        .i_waddr (w_lk_waddr),
        .i_wdata (r_top),
        .i_re    (w_lk_re),
        .i_raddr (SW'(r_top)),
        .o_rdata (w_lk_rdata)
    );

    // Start slot of the group that each slot belongs to.
    msp_ram #(
        .WIDTH (SW),
        .DEPTH (POOL_SLOTS)
    ) u_groups (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exp_step),
        .i_waddr (SW'(r_cursor)),
        .i_wdata (SW'(r_opened)),
        .i_re    (i_cmd.grp_rd),
        .i_raddr (w_gr_raddr),
        .o_rdata (w_gr_rdata)
    );

    // Result selection.
    always_comb begin
        w_emit        = 1'b0;
        w_emit_slot   = '0;
        w_emit_status = ST_OK;
        w_emit_last   = 1'b1;
        if (i_cmd.pop) begin
            w_emit      = 1'b1;
            w_emit_slot = SLOT_W'(r_top);
        end else if (i_cmd.full_err) begin
            w_emit        = 1'b1;
            w_emit_status = ST_FULL;
        end else if (i_cmd.mark_fin) begin
            w_emit        = 1'b1;
            w_emit_slot   = r_slot;
            w_emit_status = w_bad_mark ? ST_BAD_MARK : ST_OK;
        end else if (i_cmd.sw_eval) begin
            // A newer free pushes the held one out as a non-final result.
            w_emit      = w_do_free && w_report && r_pend_v;
            w_emit_slot = SLOT_W'(r_pend);
            w_emit_last = 1'b0;
        end else if (i_cmd.sw_fin) begin
            w_emit        = 1'b1;
            w_emit_slot   = r_pend_v ? SLOT_W'(r_pend) : '0;
            w_emit_status = r_pend_v ? ST_OK : ST_SWEEP_EMPTY;
        end
    end

    // Control registers: list head, open count, sweep bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top    <= CW'(POOL_SLOTS);
            r_opened <= '0;
            r_pend_v <= 1'b0;
            r_k      <= '0;
        end else begin
            if (i_cmd.exp_step) begin
                r_top <= r_cursor;
                if (o_sts.exp_last) begin
                    r_opened <= r_exp_end;
                end
            end
            if (i_cmd.pop) begin
                r_top <= w_lk_rdata;
            end
            if (i_cmd.sw_start) begin
                r_pend_v <= 1'b0;
                r_k      <= '0;
            end
            if (i_cmd.sw_eval && w_do_free) begin
                r_top <= CW'(r_cur);
                if (w_report) begin
                    r_pend_v <= 1'b1;
                    r_k      <= r_k + KW'(1);
                end
            end
            if (i_cmd.sw_fin) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    // Cursors and held slot numbers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_slot <= i_slot;
        end
        if (i_cmd.exp_start) begin
            r_cursor  <= r_opened;
            r_exp_end <= CW'(w_exp_sum);
        end
        if (i_cmd.exp_step) begin
            r_cursor <= r_cursor + CW'(1);
        end
        if (i_cmd.sw_start) begin
            r_end <= r_opened;
        end
        if (i_cmd.grp_load) begin
            r_start <= w_gr_rdata;
            r_cur   <= w_gr_rdata;
        end
        if (i_cmd.sw_eval) begin
            r_cur <= r_cur + SW'(1);
            if (o_sts.cur_last) begin
                r_end <= CW'(r_start);
            end
            if (w_do_free && w_report) begin
                r_pend <= r_cur;
            end
        end
    end

    // Output register: loads a result, drops it after the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_slot   <= w_emit_slot;
            r_out_status <= w_emit_status;
            r_out_last   <= w_emit_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_slot   = r_out_slot;
    assign o_m_status = r_out_status;
    assign o_m_last   = r_out_last;

    // A waiting result is never overwritten.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !w_emit)
        else $error("result register overwritten while stalled");

    // The list head is a slot or the empty mark.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= CW'(POOL_SLOTS))
        else $error("free list head out of range");

    // The pool never opens more slots than it has.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_opened <= CW'(POOL_SLOTS))
        else $error("open slot count beyond pool size");

    // Expansion writes stay inside the group being opened.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exp_step |-> (r_cursor < r_exp_end))
        else $error("expansion cursor past group end");

    // The report count of a sweep stays within its cap.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= KW'(MAX_RESULTS))
        else $error("sweep report count beyond cap");

endmodule

// ----- hw/rtl/mark_sweep_slot_pool_top.sv -----
// Top level of the mark-and-sweep slot pool: stream ports and configuration register.
//
// Requests arrive on the s_axis channel: tuser carries the kind (allocate,
// mark, sweep) and tdata the slot to mark. Results leave on the m_axis
// channel, one per allocate or mark request and one per freed slot of a
// sweep (or a single status-only result when it frees nothing); tlast marks
// the final result of each request. The configuration channel writes the
// number of slots opened per expansion; it is always ready. The user must
// write it only while the block is idle; the block does not enforce this.
// The block works on one request at a time; s_axis_tready is high only when
// it is idle. An allocate from a non-empty list reads the list head and a
// mark reads the slot's flags; each then loads its result and returns to idle.
// An allocate that opens a new group first opens its slots one at a time and
// then reads the new list head. A sweep reads each group's start, newest
// first, and then each slot's flags, registered, before evaluating the slot;
// its last result is loaded in its final state.
// Reset empties the free list, opens no slots and sets the expansion count
// to 8; the slot memories need no clearing pass. When the receiver stalls,
// the result waits in the output register; the work stops before the next one.
module mark_sweep_slot_pool_top
    import msp_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [5:0] slot, [7:6] zero
    input  logic [KIND_W-1:0] s_axis_tuser,   // [1:0] kind
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [5:0] slot_index, [7:6] status
    output logic              m_axis_tlast,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [ECNT_W-1:0] i_cfg_data
);

    logic [ECNT_W-1:0] r_expand_count;
    t_cmd              w_cmd;
    t_sts              w_sts;
    logic [SLOT_W-1:0] w_m_slot;
    logic [STAT_W-1:0] w_m_status;

    // Expansion count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expand_count <= EXPAND_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_expand_count <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    msp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_kind  (s_axis_tuser),
        .o_req_ready (s_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    msp_dp #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_slot         (s_axis_tdata[SLOT_W-1:0]),
        .i_expand_count (r_expand_count),
        .i_m_tready     (m_axis_tready),
        .o_m_tvalid     (m_axis_tvalid),
        .o_m_slot       (w_m_slot),
        .o_m_status     (w_m_status),
        .o_m_last       (m_axis_tlast)
    );

    // Result packing.
    assign m_axis_tdata = {w_m_status, w_m_slot};

endmodule

// ----- dv/tb_mark_sweep_slot_pool_top.sv -----
// Self-checking testbench for the mark-and-sweep slot pool, with a built-in pool predictor.
module tb_mark_sweep_slot_pool_top;
    import msp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Kind code that the block ignores.
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
    localparam int POOL = POOL_SLOTS_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int IDLE_SETTLE = 20;
    localparam int END_SETTLE = 300;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        logic [STAT_W-1:0] status;
        logic              last;
    } t_pool_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;   // [5:0] slot, [7:6] zero
    logic [KIND_W-1:0] s_axis_tuser = '0;   // [1:0] kind
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;        // [5:0] slot_index, [7:6] status
    logic              m_axis_tlast;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [ECNT_W-1:0] i_cfg_data = '0;

    // Predicted pool state.
    bit [1:0]          slot_flags [POOL];
    bit [6:0]          next_free [POOL];
    bit                group_start [POOL];
    bit [6:0]          list_head = 7'(POOL);
    int                opened_count = 0;
    bit [ECNT_W-1:0]   expand_reg = EXPAND_RESET;

    t_pool_result      expected_results [$];
    int                err_count = 0;
    int                cycle_count = 0;
    int                burst_left = 0;
    int                rdy_hold = 0;
    int                rdy_mode = 0;
    int                rx_cycle = 0;

    mark_sweep_slot_pool_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Count errors; only the first few are described.
    function automatic void note_error(string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
        end
    endfunction

    function automatic void expect_result(logic [SLOT_W-1:0] idx, logic [STAT_W-1:0] st,
                                          logic lst);
        t_pool_result r;
        r.slot_index = idx;
        r.status = st;
        r.last = lst;
        expected_results.push_back(r);
    endfunction

    function automatic void push_free(int s);
        next_free[s] = list_head;
        list_head = 7'(s);
    endfunction

    // Allocate: pop the free list, opening a new group first if it is empty.
    function automatic void predict_alloc();
        int n;
        int base;
        int s;
        if (list_head == 7'(POOL)) begin
            n = (expand_reg == 0) ? 1 : int'(expand_reg);
            base = opened_count;
            if (n > POOL || base > POOL - n) begin
                expect_result('0, ST_FULL, 1'b1);
                return;
            end
            for (int i = 0; i < n; i++) begin
                slot_flags[base + i] = FLAG_FREE;
                group_start[base + i] = (i == 0);
                push_free(base + i);
            end
            opened_count = base + n;
        end
        s = list_head;
        list_head = next_free[s];
        slot_flags[s] = 2'b00;
        expect_result(SLOT_W'(s), ST_OK, 1'b1);
    endfunction

    function automatic void predict_mark(logic [SLOT_W-1:0] slot);
        if (int'(slot) >= opened_count || (slot_flags[slot] & FLAG_FREE) != 2'b00) begin
            expect_result(slot, ST_BAD_MARK, 1'b1);
        end else begin
            slot_flags[slot] = slot_flags[slot] | FLAG_MARKED;
            expect_result(slot, ST_OK, 1'b1);
        end
    endfunction

    // Sweep: groups newest first, slots ascending inside a group.
    function automatic void predict_sweep();
        int top_bound;
        int grp_lo;
        int freed;
        t_pool_result tail;
        freed = 0;
        top_bound = opened_count;
        while (top_bound > 0) begin
            grp_lo = top_bound - 1;
            while (grp_lo > 0 && !group_start[grp_lo]) grp_lo--;
            for (int s = grp_lo; s < top_bound; s++) begin
                if ((slot_flags[s] & (FLAG_MARKED | FLAG_FREE)) == 2'b00) begin
                    slot_flags[s] = slot_flags[s] | FLAG_FREE;
                    push_free(s);
                    expect_result(SLOT_W'(s), ST_OK, 1'b0);
                    freed++;
                end else begin
                    slot_flags[s] = slot_flags[s] & ~FLAG_MARKED;
                end
            end
            top_bound = grp_lo;
        end
        if (freed == 0) begin
            expect_result('0, ST_SWEEP_EMPTY, 1'b1);
        end else begin
            tail = expected_results.pop_back();
            tail.last = 1'b1;
            expected_results.push_back(tail);
        end
    endfunction

    function automatic void predict_request(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot);
        case (kind)
            KIND_ALLOC: predict_alloc();
            KIND_MARK:  predict_mark(slot);
            KIND_SWEEP: predict_sweep();
            default: ;
        endcase
    endfunction

    // A slot that is currently handed out, or any slot when none is.
    function automatic logic [SLOT_W-1:0] pick_live_slot();
        logic [SLOT_W-1:0] live [$];
        for (int i = 0; i < opened_count; i++) begin
            if ((slot_flags[i] & FLAG_FREE) == 2'b00) live.push_back(SLOT_W'(i));
        end
        if (live.size() == 0) return SLOT_W'($urandom_range(0, POOL - 1));
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    // Send one request; entered and left just after a falling edge.
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
                burst_left = 40;
                gap = 0;
            end else begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, slot};
        s_axis_tuser <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_request(kind, slot);
        @(negedge i_clk);
        burst_left--;
    endtask

    // Hold off the sender until every expected result has come back.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
    endtask

    // Write the expansion count while the block is idle.
    task automatic write_expand(input logic [ECNT_W-1:0] value);
        wait_for_drain();
        while (!s_axis_tready) @(negedge i_clk);
        repeat (IDLE_SETTLE) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        expand_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Requests on a pool with no open slot, and the ignored kind.
    task automatic test_empty_pool();
        send_request(KIND_SWEEP, 6'd21);
        send_request(KIND_MARK, 6'd0);
        send_request(KIND_MARK, 6'd63);
        send_request(KIND_NONE, 6'd63);
    endtask

    // First expansion at the reset count, then marks of live, free and unopened slots.
    task automatic test_first_group();
        send_request(KIND_ALLOC, 6'd42);
        send_request(KIND_MARK, 6'd7);
        send_request(KIND_MARK, 6'd7);
        send_request(KIND_MARK, 6'd6);
        send_request(KIND_MARK, 6'd8);
    endtask

    // A count that cannot fit, a zero count and a count of one.
    task automatic test_config_extremes();
        write_expand(7'd127);
        repeat (8) send_request(KIND_ALLOC, 6'd0);
        write_expand(7'd0);
        send_request(KIND_ALLOC, 6'd0);
        send_request(KIND_MARK, 6'd8);
        write_expand(7'd1);
        send_request(KIND_ALLOC, 6'd63);
    endtask

    // Sweep order across groups of different sizes, then a sweep of the unmarked rest.
    task automatic test_sweep_order();
        send_request(KIND_SWEEP, 6'd0);
        send_request(KIND_SWEEP, 6'd63);
        write_expand(7'd64);
    endtask

    // Rounds of allocations, marks of live slots and a sweep, with stray requests.
    task automatic test_random_rounds(input logic [ECNT_W-1:0] count, input int items);
        int sent;
        int k;
        int n;
        write_expand(count);
        sent = 0;
        while (sent < items) begin
            n = $urandom_range(1, 8);
            repeat (n) begin
                send_request(KIND_ALLOC, SLOT_W'($urandom_range(0, POOL - 1)));
                sent++;
            end
            n = $urandom_range(0, 8);
            repeat (n) begin
                if ($urandom_range(0, 5) == 0) begin
                    k = $urandom_range(0, 3);
                    send_request(KIND_W'(k), SLOT_W'($urandom_range(0, POOL - 1)));
                    if (k != KIND_NONE) sent++;
                end else begin
                    send_request(KIND_MARK, pick_live_slot());
                    sent++;
                end
            end
            send_request(KIND_SWEEP, SLOT_W'($urandom_range(0, POOL - 1)));
            sent++;
            if ($urandom_range(0, 7) == 0) wait_for_drain();
        end
    endtask

    // Receiver readiness switches among its own patterns.
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rdy_hold == 0) begin
            rdy_mode <= $urandom_range(0, 3);
            rdy_hold <= $urandom_range(20, 200);
        end else begin
            rdy_hold <= rdy_hold - 1;
        end
        case (rdy_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (rx_cycle % 8 != 0);
        endcase
    end

    // Compare every result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_pool_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                note_error($sformatf("unexpected result slot %0d status %0d last %0d",
                                     m_axis_tdata[5:0], m_axis_tdata[7:6], m_axis_tlast));
            end else begin
                exp_r = expected_results.pop_front();
                if (m_axis_tdata[5:0] !== exp_r.slot_index ||
                    m_axis_tdata[7:6] !== exp_r.status ||
                    m_axis_tlast !== exp_r.last) begin
                    note_error($sformatf(
                        "expected slot %0d status %0d last %0d, got slot %0d status %0d last %0d",
                        exp_r.slot_index, exp_r.status, exp_r.last,
                        m_axis_tdata[5:0], m_axis_tdata[7:6], m_axis_tlast));
                end
            end
        end
    end

    // Watchdog against a hung block.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_pool();
        test_first_group();
        test_config_extremes();
        test_sweep_order();
        test_random_rounds(7'd3, 68);
        test_random_rounds(7'd0, 68);
        test_random_rounds(7'd12, 68);
        test_random_rounds(7'd127, 68);
        test_random_rounds(7'($urandom_range(1, 64)), 68);
        test_random_rounds(7'd64, 68);

        wait_for_drain();
        repeat (END_SETTLE) @(negedge i_clk);
        if (err_count == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- mark_sweep_slot_pool_top.f -----
hw/rtl/msp_pkg.sv
hw/rtl/msp_ram.sv
hw/rtl/msp_ctrl.sv
hw/rtl/msp_dp.sv
hw/rtl/mark_sweep_slot_pool_top.sv
dv/tb_mark_sweep_slot_pool_top.sv
